@@ rtl/core/ptsg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and microprogram for the pan/tilt sweep and goto slewer.
package ptsg_pkg;

    localparam int NUM_AXES_DEF = 2;

    localparam int ANG_W      = 17;
    localparam int VEL_W      = 16;
    localparam int TOL_W      = 16;
    localparam int MID_W      = 32;
    localparam int DT_W       = 17;
    localparam int KIND_W     = 2;
    localparam int MODE_W     = 2;
    localparam int AXIS_W     = 2;
    localparam int MOTOR_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [DT_W-1:0] DT_DEFAULT = 17'd1311;
    localparam logic [DT_W-1:0] DT_MAX     = 17'd65536;

    // input item kinds
    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_TICK     = 2'd0;
    localparam t_kind KIND_SET_MODE = 2'd1;
    localparam t_kind KIND_SET_GOAL = 2'd2;

    // run modes; code 3 is stored and acts as idle
    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_IDLE  = 2'd0;
    localparam t_mode MODE_SWEEP = 2'd1;
    localparam t_mode MODE_GOTO  = 2'd2;

    // config register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LIM_LO   = 3'd0;
    localparam t_cfg_idx CFG_LIM_HI   = 3'd1;
    localparam t_cfg_idx CFG_VELOCITY = 3'd2;
    localparam t_cfg_idx CFG_TOLERANCE = 3'd3;
    localparam t_cfg_idx CFG_DRIVE_IDS = 3'd4;

    // datapath operations, one per microinstruction
    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,
        OP_MUL,
        OP_SEL,
        OP_ERR,
        OP_MOVE,
        OP_CLAMP,
        OP_CHK,
        OP_STORE,
        OP_SCAN,
        OP_EMIT,
        OP_NEXT,
        OP_HOLD
    } t_op;

    // jump conditions: jump when true, else fall through
    typedef enum logic [2:0] {
        J_NONE,
        J_ALWAYS,
        J_NO_TICK,
        J_HOLD,
        J_NO_SCAN,
        J_SCAN_MORE,
        J_OUT_BUSY,
        J_MORE_AXES
    } t_jmp;

    localparam int UPC_W      = 4;
    localparam int UROM_DEPTH = 13;
    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc UA_IDLE  = 4'd0;
    localparam t_upc UA_MUL   = 4'd1;
    localparam t_upc UA_SEL   = 4'd2;
    localparam t_upc UA_ERR   = 4'd3;
    localparam t_upc UA_MOVE  = 4'd4;
    localparam t_upc UA_CLAMP = 4'd5;
    localparam t_upc UA_CHK   = 4'd6;
    localparam t_upc UA_STORE = 4'd7;
    localparam t_upc UA_SCAN  = 4'd8;
    localparam t_upc UA_EMIT  = 4'd9;
    localparam t_upc UA_NEXT  = 4'd10;
    localparam t_upc UA_END   = 4'd11;
    localparam t_upc UA_HOLD  = 4'd12;

    typedef struct packed {
        t_op  op;
        t_jmp jmp;
        t_upc addr;
    } t_uword;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic tick_go;
        logic mode_moving;
        logic no_scan;
        logic scan_more;
        logic out_busy;
        logic more_axes;
    } t_dp_stat;

    function automatic t_uword urom(input t_upc pc);
        t_uword w;
        unique case (pc)
            UA_IDLE:  w = '{op: OP_IDLE,  jmp: J_NO_TICK,   addr: UA_IDLE};
            UA_MUL:   w = '{op: OP_MUL,   jmp: J_NONE,      addr: UA_IDLE};
            UA_SEL:   w = '{op: OP_SEL,   jmp: J_HOLD,      addr: UA_HOLD};
            UA_ERR:   w = '{op: OP_ERR,   jmp: J_NONE,      addr: UA_IDLE};
            UA_MOVE:  w = '{op: OP_MOVE,  jmp: J_NONE,      addr: UA_IDLE};
            UA_CLAMP: w = '{op: OP_CLAMP, jmp: J_NONE,      addr: UA_IDLE};
            UA_CHK:   w = '{op: OP_CHK,   jmp: J_NONE,      addr: UA_IDLE};
            UA_STORE: w = '{op: OP_STORE, jmp: J_NO_SCAN,   addr: UA_EMIT};
            UA_SCAN:  w = '{op: OP_SCAN,  jmp: J_SCAN_MORE, addr: UA_SCAN};
            UA_EMIT:  w = '{op: OP_EMIT,  jmp: J_OUT_BUSY,  addr: UA_EMIT};
            UA_NEXT:  w = '{op: OP_NEXT,  jmp: J_MORE_AXES, addr: UA_SEL};
            UA_END:   w = '{op: OP_NOP,   jmp: J_ALWAYS,    addr: UA_IDLE};
            UA_HOLD:  w = '{op: OP_HOLD,  jmp: J_ALWAYS,    addr: UA_EMIT};
            default:  w = '{op: OP_NOP,   jmp: J_ALWAYS,    addr: UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/pan_tilt_sweep_goto_slewer_top.sv @@
`timescale 1ns / 1ps
// Top level of the pan/tilt sweep and goto slewer: sequencer plus datapath.
//
//  channel  dir  handshake                 payload
//  -------  ---  ------------------------  ---------------------------------------------
//  in       in   i_in_valid / o_in_stall   i_kind i_goal_axis i_goal_angle i_new_mode
//                                          i_tick_time
//  out      out  o_out_valid / i_out_stall o_out_axis o_drive_id o_command_angle
//                                          o_command_velocity o_last_axis
//  cfg      in   i_cfg_we                  i_cfg_idx i_cfg_wdata
//
// After a set-mode or set-goal item the next item can transfer the cycle after. A tick
// computes the step; the microprogram then walks the axes one at a time through a single
// slew datapath: select, error, move, clamp, check, store, the arrival scan when a goto
// axis lands, emit and next for a moving axis; select, hold, emit and next for a held
// axis. Reset is synchronous, active low; the mode, stores and config return to defaults.
// A stalled output holds the emit step; input is taken only at the idle step.
module pan_tilt_sweep_goto_slewer_top
    import ptsg_pkg::*;
#(
    parameter int NUM_AXES = NUM_AXES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // config write port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_wdata,
    // input items
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [AXIS_W-1:0]        i_goal_axis,
    input  logic signed [ANG_W-1:0]  i_goal_angle,
    input  logic [MODE_W-1:0]        i_new_mode,
    input  logic [DT_W-1:0]          i_tick_time,
    // per-axis commands
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [AXIS_W-1:0]        o_out_axis,
    output logic [MOTOR_W-1:0]       o_drive_id,
    output logic signed [ANG_W-1:0]  o_command_angle,
    output logic [VEL_W-1:0]         o_command_velocity,
    output logic                     o_last_axis
);

    t_op      w_op;
    t_dp_stat w_stat;

    // control ROM and step counter
    ptsg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_op    (w_op)
    );

    // slew arithmetic, axis stores, config and output register
    ptsg_dp #(
        .NUM_AXES (NUM_AXES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_op               (w_op),
        .o_stat             (w_stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_goal_axis        (i_goal_axis),
        .i_goal_angle       (i_goal_angle),
        .i_new_mode         (i_new_mode),
        .i_tick_time        (i_tick_time),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_axis         (o_out_axis),
        .o_drive_id         (o_drive_id),
        .o_command_angle    (o_command_angle),
        .o_command_velocity (o_command_velocity),
        .o_last_axis        (o_last_axis)
    );

endmodule

@@ rtl/core/ptsg_seq.sv @@
`timescale 1ns / 1ps
// Microprogram sequencer: step counter, control ROM lookup and conditional jumps.
module ptsg_seq
    import ptsg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_op      o_op
);

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword w_uw;
    logic   w_take;

    assign w_uw = urom(r_pc);
    assign o_op = w_uw.op;

    always_comb begin
        unique case (w_uw.jmp)
            J_NONE:      w_take = 1'b0;
            J_ALWAYS:    w_take = 1'b1;
            J_NO_TICK:   w_take = !i_stat.tick_go;
            J_HOLD:      w_take = !i_stat.mode_moving;
            J_NO_SCAN:   w_take = i_stat.no_scan;
            J_SCAN_MORE: w_take = i_stat.scan_more;
            J_OUT_BUSY:  w_take = i_stat.out_busy;
            J_MORE_AXES: w_take = i_stat.more_axes;
            default:     w_take = 1'b1;
        endcase
        n_pc = w_take ? w_uw.addr : t_upc'(r_pc + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UA_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    a_pc_in_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc < t_upc'(UROM_DEPTH))
        else $error("step counter left the control ROM");

    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_IDLE && i_stat.tick_go) |=> r_pc == UA_MUL)
        else $error("accepted tick did not start the step computation");

endmodule

@@ rtl/core/ptsg_dp.sv @@
`timescale 1ns / 1ps
// Datapath: config registers, per-axis stores, slew arithmetic and output register.
module ptsg_dp
    import ptsg_pkg::*;
#(
    parameter int NUM_AXES = NUM_AXES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_op                          i_op,
    output t_dp_stat                     o_stat,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [KIND_W-1:0]            i_kind,
    input  logic [AXIS_W-1:0]            i_goal_axis,
    input  logic signed [ANG_W-1:0]      i_goal_angle,
    input  logic [MODE_W-1:0]            i_new_mode,
    input  logic [DT_W-1:0]              i_tick_time,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [AXIS_W-1:0]            o_out_axis,
    output logic [MOTOR_W-1:0]           o_drive_id,
    output logic signed [ANG_W-1:0]      o_command_angle,
    output logic [VEL_W-1:0]             o_command_velocity,
    output logic                         o_last_axis
);

    localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam logic [AXW-1:0] AX_LAST = AXW'(NUM_AXES - 1);

    // |a - b| on 17-bit signed values
    function automatic logic [ANG_W:0] f_dist(input logic signed [ANG_W-1:0] a,
                                              input logic signed [ANG_W-1:0] b);
        logic signed [ANG_W:0] d;
        d = (ANG_W+1)'(a) - (ANG_W+1)'(b);
        return d[ANG_W] ? (ANG_W+1)'(-d) : (ANG_W+1)'(d);
    endfunction

    function automatic logic signed [ANG_W-1:0] f_clamp(input logic signed [ANG_W:0] v,
                                                        input logic signed [ANG_W-1:0] lo,
                                                        input logic signed [ANG_W-1:0] hi);
        logic signed [ANG_W-1:0] r;
        if (v < (ANG_W+1)'(lo)) begin
            r = lo;
        end else if (v > (ANG_W+1)'(hi)) begin
            r = hi;
        end else begin
            r = v[ANG_W-1:0];
        end
        return r;
    endfunction

    // config
    logic signed [ANG_W-1:0] r_lim_a;
    logic signed [ANG_W-1:0] r_lim_b;
    logic [VEL_W-1:0]        r_vel;
    logic [TOL_W-1:0]        r_tol;
    logic [MID_W-1:0]        r_mid;

    // architectural state
    t_mode                   r_mode;
    logic signed [ANG_W-1:0] r_goal [NUM_AXES];
    logic signed [ANG_W-1:0] r_cmd  [NUM_AXES];
    logic                    r_up   [NUM_AXES];

    // working registers
    logic [DT_W-1:0]         r_dt;
    logic [VEL_W-1:0]        r_step;
    logic [AXW-1:0]          r_axis;
    logic [AXW-1:0]          r_j;
    logic signed [ANG_W-1:0] r_tgt;
    logic signed [ANG_W-1:0] r_cur;
    logic                    r_err_pos;
    logic [ANG_W:0]          r_dist;
    logic signed [ANG_W:0]   r_cand;
    logic                    r_hit;
    logic signed [ANG_W-1:0] r_ang;
    logic                    r_near;
    logic                    r_moving;
    logic                    r_sweep;
    logic                    r_done;

    // output register
    logic                    r_out_valid;
    logic [AXIS_W-1:0]       r_o_axis;
    logic [MOTOR_W-1:0]      r_o_mid;
    logic signed [ANG_W-1:0] r_o_ang;
    logic [VEL_W-1:0]        r_o_vel;
    logic                    r_o_last;

    logic                    w_accept;
    logic                    w_out_busy;
    logic signed [ANG_W-1:0] w_lmin;
    logic signed [ANG_W-1:0] w_lmax;
    logic [DT_W-1:0]         w_dt_eff;
    logic signed [ANG_W-1:0] w_goal_cl;
    logic                    w_goal_ok;
    logic [AXW-1:0]          w_rd;
    logic signed [ANG_W-1:0] w_goal_rd;
    logic signed [ANG_W-1:0] w_cmd_rd;
    logic                    w_up_rd;
    logic [VEL_W+DT_W-1:0]   w_prod;
    logic signed [ANG_W-1:0] w_tgt_sel;
    logic signed [ANG_W:0]   w_step_s;
    logic signed [ANG_W:0]   w_cur_s;
    logic                    w_scan_ok;
    logic [AXIS_W-1:0]       w_ax_out;

    assign w_accept   = i_in_valid && (i_op == OP_IDLE);
    assign o_in_stall = (i_op != OP_IDLE);
    assign w_out_busy = r_out_valid && i_out_stall;

    // smaller limit is the minimum
    assign w_lmin = (r_lim_a < r_lim_b) ? r_lim_a : r_lim_b;
    assign w_lmax = (r_lim_a < r_lim_b) ? r_lim_b : r_lim_a;

    assign w_dt_eff  = (i_tick_time == '0 || i_tick_time > DT_MAX) ? DT_DEFAULT : i_tick_time;
    assign w_goal_cl = f_clamp((ANG_W+1)'(i_goal_angle), w_lmin, w_lmax);
    assign w_goal_ok = {1'b0, i_goal_axis} < (AXIS_W+1)'(NUM_AXES);

    // one read address into the axis stores: scan index during the arrival scan
    assign w_rd      = (i_op == OP_SCAN) ? r_j : r_axis;
    assign w_goal_rd = r_goal[w_rd];
    assign w_cmd_rd  = r_cmd[w_rd];
    assign w_up_rd   = r_up[w_rd];

    assign w_prod    = (VEL_W+DT_W)'(r_vel) * (VEL_W+DT_W)'(r_dt);
    assign w_tgt_sel = (r_mode == MODE_SWEEP) ? (w_up_rd ? w_lmax : w_lmin) : w_goal_rd;
    assign w_step_s  = $signed({2'b00, r_step});
    assign w_cur_s   = (ANG_W+1)'(r_cur);
    assign w_scan_ok = f_dist(w_goal_rd, w_cmd_rd) < {2'b00, r_tol};
    assign w_ax_out  = AXIS_W'(r_axis);

    always_comb begin
        o_stat.tick_go     = w_accept && (i_kind == KIND_TICK);
        o_stat.mode_moving = (r_mode == MODE_SWEEP) || (r_mode == MODE_GOTO);
        o_stat.no_scan     = !(r_moving && !r_sweep && r_near);
        o_stat.scan_more   = (r_j != AX_LAST);
        o_stat.out_busy    = w_out_busy;
        o_stat.more_axes   = (r_axis != AX_LAST);
    end

    // config port; writes beyond the register list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_a <= -17'sd23040;
            r_lim_b <= 17'sd23040;
            r_vel   <= 16'd7680;
            r_tol   <= 16'd128;
            r_mid   <= 32'd513;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIM_LO:    r_lim_a <= i_cfg_wdata[ANG_W-1:0];
                CFG_LIM_HI:    r_lim_b <= i_cfg_wdata[ANG_W-1:0];
                CFG_VELOCITY:  r_vel   <= i_cfg_wdata[VEL_W-1:0];
                CFG_TOLERANCE: r_tol   <= i_cfg_wdata[TOL_W-1:0];
                CFG_DRIVE_IDS: r_mid   <= i_cfg_wdata[MID_W-1:0];
                default: ;
            endcase
        end
    end

    // state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_goal[k] <= '0;
                r_cmd[k]  <= '0;
                r_up[k]   <= 1'b1;
            end
            r_out_valid <= 1'b0;
            r_axis      <= '0;
            r_j         <= '0;
            r_done      <= 1'b0;
        end else begin
            // the emit step reloads or keeps the output register itself
            if (r_out_valid && !i_out_stall && i_op != OP_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_op)
                OP_IDLE: begin
                    if (w_accept && i_kind == KIND_SET_MODE) begin
                        r_mode <= i_new_mode;
                    end else if (w_accept && i_kind == KIND_SET_GOAL && w_goal_ok) begin
                        r_goal[i_goal_axis[AXW-1:0]] <= w_goal_cl;
                    end
                end
                OP_MUL: r_axis <= '0;
                OP_STORE: begin
                    r_cmd[r_axis] <= r_ang;
                    if (r_sweep && r_near) begin
                        r_up[r_axis] <= !w_up_rd;
                    end
                    r_j    <= '0;
                    r_done <= 1'b1;
                end
                OP_SCAN: begin
                    if (!w_scan_ok) begin
                        r_done <= 1'b0;
                    end
                    if (r_j == AX_LAST) begin
                        if (r_done && w_scan_ok) begin
                            r_mode <= MODE_IDLE;
                        end
                    end else begin
                        r_j <= AXW'(r_j + 1'b1);
                    end
                end
                OP_EMIT: begin
                    if (!w_out_busy) begin
                        r_out_valid <= 1'b1;
                    end
                end
                OP_NEXT: begin
                    if (r_axis != AX_LAST) begin
                        r_axis <= AXW'(r_axis + 1'b1);
                    end
                end
                default: ;
            endcase
        end
    end

    // working values and output payload
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_IDLE: begin
                if (w_accept && i_kind == KIND_TICK) begin
                    r_dt <= w_dt_eff;
                end
            end
            OP_MUL: r_step <= w_prod[VEL_W+DT_W-2:DT_W-1];
            OP_SEL: begin
                r_moving <= (r_mode == MODE_SWEEP) || (r_mode == MODE_GOTO);
                r_sweep  <= (r_mode == MODE_SWEEP);
                r_tgt    <= w_tgt_sel;
                r_cur    <= w_cmd_rd;
            end
            OP_ERR: begin
                r_err_pos <= (r_tgt > r_cur);
                r_dist    <= f_dist(r_tgt, r_cur);
            end
            OP_MOVE: begin
                r_hit  <= (r_dist < {2'b00, r_tol}) || ({2'b00, r_step} >= r_dist);
                r_cand <= r_err_pos ? (w_cur_s + w_step_s) : (w_cur_s - w_step_s);
            end
            OP_CLAMP: r_ang  <= r_hit ? r_tgt : f_clamp(r_cand, w_lmin, w_lmax);
            OP_CHK:   r_near <= f_dist(r_tgt, r_ang) < {2'b00, r_tol};
            OP_HOLD:  r_ang  <= w_cmd_rd;
            OP_EMIT: begin
                if (!w_out_busy) begin
                    r_o_axis <= w_ax_out;
                    r_o_mid  <= r_mid[MOTOR_W*w_ax_out +: MOTOR_W];
                    r_o_ang  <= r_ang;
                    r_o_vel  <= r_moving ? r_vel : '0;
                    r_o_last <= (r_axis == AX_LAST);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_axis         = r_o_axis;
    assign o_drive_id         = r_o_mid;
    assign o_command_angle    = r_o_ang;
    assign o_command_velocity = r_o_vel;
    assign o_last_axis        = r_o_last;

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis <= AX_LAST)
        else $error("axis index past last axis");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j <= AX_LAST)
        else $error("scan index past last axis");

    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_op == OP_EMIT))
        else $error("output loaded outside the emit step");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the pan/tilt sweep and goto slewer top level.
//
// A behavioral copy of the slewer runs beside the block. Every transfer the
// block takes on its input channel is fed to that copy at the same edge, and
// the per-axis commands it works out are queued. The command checker pops one
// entry per output transfer and compares it field by field.
//
// Flow: short directed tests at the reset register values (idle hold, odd
// codes, sweep with reversal, goto that finishes mid-tick), then random
// goto/sweep runs over six register settings with three idling patterns, then
// a back-pressure test where the receiver holds off for a long stretch.
module tb_top;
    import ptsg_pkg::*;

    localparam int AXES        = NUM_AXES_DEF;
    localparam int TAIL_CYCLES = 40;     // settling time after the last queued command
    localparam int QUIET_LIMIT = 2000;   // cycles with no transfer before giving up
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off for the pressure test

    // codes the package does not name; the block must cope with them anyway
    localparam t_kind KIND_UNUSED = 2'd3;
    localparam t_mode MODE_UNUSED = 2'd3;

    typedef struct {
        t_kind                   kind;
        logic [AXIS_W-1:0]       axis;
        logic signed [ANG_W-1:0] angle;
        t_mode                   mode;
        logic [DT_W-1:0]         dt;
    } t_slew_item;

    typedef struct {
        logic [AXIS_W-1:0]       axis;
        logic [MOTOR_W-1:0]      motor;
        logic signed [ANG_W-1:0] angle;
        logic [VEL_W-1:0]        vel;
        logic                    last;
    } t_axis_cmd;

    // ---------------------------------------------------------------------
    // DUT hookup
    // ---------------------------------------------------------------------
    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [KIND_W-1:0]       i_kind;
    logic [AXIS_W-1:0]       i_goal_axis;
    logic signed [ANG_W-1:0] i_goal_angle;
    logic [MODE_W-1:0]       i_new_mode;
    logic [DT_W-1:0]         i_tick_time;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [AXIS_W-1:0]       o_out_axis;
    logic [MOTOR_W-1:0]      o_drive_id;
    logic signed [ANG_W-1:0] o_command_angle;
    logic [VEL_W-1:0]        o_command_velocity;
    logic                    o_last_axis;

    pan_tilt_sweep_goto_slewer_top #(.NUM_AXES(AXES)) dut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Slewer state mirror: registers plus per-axis stores
    // ---------------------------------------------------------------------
    longint      lim_a, lim_b;          // limit registers as written; min/max taken at use
    longint      slew_vel, arrive_tol;
    logic [31:0] drive_ids;
    t_mode       run_mode;
    longint      goal_pos [AXES];
    longint      cmd_pos  [AXES];
    bit          sweep_up [AXES];

    t_axis_cmd   pending_cmds [$];

    // run bookkeeping
    int snd_idle_pct = 28;
    int rcv_idle_pct = 59;
    int hold_len     = 0;
    int quiet_cycles = 0;
    int n_fail       = 0;
    int n_items      = 0;
    int n_ticks      = 0;
    int n_results    = 0;
    int n_goto_done  = 0;
    int n_reversals  = 0;
    int n_in_held    = 0;

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint dist_of(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    // one constant-velocity step of axis ax toward target
    function automatic longint slew_to(int ax, longint target, longint step,
                                       longint lo, longint hi);
        longint cur;
        longint d;
        cur = cmd_pos[ax];
        d   = dist_of(target, cur);
        if (d < arrive_tol || step >= d) return target;
        return clamp_to((target > cur) ? cur + step : cur - step, lo, hi);
    endfunction

    // Apply one accepted input transfer; queue the commands a tick produces.
    function automatic void advance_slewer(t_slew_item it);
        longint    lo, hi, dt, step, target, ang, vel;
        bit        done;
        t_axis_cmd c;
        lo = (lim_a < lim_b) ? lim_a : lim_b;
        hi = (lim_a < lim_b) ? lim_b : lim_a;
        unique case (it.kind)
            KIND_SET_MODE: run_mode = it.mode;
            KIND_SET_GOAL: begin
                if (it.axis < AXES)
                    goal_pos[it.axis] = clamp_to(longint'(it.angle), lo, hi);
            end
            KIND_TICK: begin
                n_ticks++;
                dt = longint'(it.dt);
                if (dt == 0 || dt > longint'(DT_MAX))
                    dt = longint'(DT_DEFAULT);
                step = (slew_vel * dt) >> 16;
                for (int i = 0; i < AXES; i++) begin
                    if (run_mode == MODE_SWEEP) begin
                        target = sweep_up[i] ? hi : lo;
                        ang    = slew_to(i, target, step, lo, hi);
                        if (dist_of(target, ang) < arrive_tol) begin
                            sweep_up[i] = !sweep_up[i];
                            ang = clamp_to(ang, lo, hi);
                            n_reversals++;
                        end
                        cmd_pos[i] = ang;
                        vel = slew_vel;
                    end else if (run_mode == MODE_GOTO) begin
                        target     = goal_pos[i];
                        ang        = slew_to(i, target, step, lo, hi);
                        cmd_pos[i] = ang;
                        if (dist_of(target, ang) < arrive_tol) begin
                            // every axis in tolerance ends the move; later axes then hold
                            done = 1'b1;
                            for (int j = 0; j < AXES; j++)
                                if (dist_of(goal_pos[j], cmd_pos[j]) >= arrive_tol)
                                    done = 1'b0;
                            if (done) begin
                                run_mode = MODE_IDLE;
                                n_goto_done++;
                            end
                        end
                        vel = slew_vel;
                    end else begin
                        // idle and the unused mode code both hold position
                        ang = cmd_pos[i];
                        vel = 0;
                    end
                    c.axis  = AXIS_W'(i);
                    c.motor = drive_ids[8*i +: 8];
                    c.angle = ANG_W'(ang);
                    c.vel   = VEL_W'(vel);
                    c.last  = (i == AXES - 1);
                    pending_cmds.push_back(c);
                end
            end
            default: ;  // unused kind code: dropped
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Item builders and random values
    // ---------------------------------------------------------------------
    function automatic t_slew_item tick_item(int dt);
        t_slew_item it;
        it.kind  = KIND_TICK;
        it.axis  = AXIS_W'($urandom_range(3));
        it.angle = ANG_W'($urandom());
        it.mode  = MODE_W'($urandom_range(3));
        it.dt    = DT_W'(dt);
        return it;
    endfunction

    function automatic t_slew_item mode_item(t_mode m);
        t_slew_item it;
        it      = tick_item($urandom_range(131071));
        it.kind = KIND_SET_MODE;
        it.mode = m;
        return it;
    endfunction

    function automatic t_slew_item goal_item(int ax, int ang);
        t_slew_item it;
        it       = tick_item($urandom_range(131071));
        it.kind  = KIND_SET_GOAL;
        it.axis  = AXIS_W'(ax);
        it.angle = ANG_W'(ang);
        return it;
    endfunction

    function automatic int rand_angle();
        return int'($urandom_range(92160)) - 46080;
    endfunction

    // tick times lean toward large steps so goto moves actually finish
    function automatic int rand_dt();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return 0;
        if (r < 10) return $urandom_range(131071, 65537);
        if (r < 15) return 65536;
        if (r < 55) return $urandom_range(65535, 16384);
        return $urandom_range(16383, 1);
    endfunction

    function automatic t_slew_item noise_item();
        t_slew_item it;
        it       = tick_item(rand_dt());
        it.kind  = KIND_W'($urandom_range(3));
        it.angle = ANG_W'(rand_angle());
        return it;
    endfunction

    // ---------------------------------------------------------------------
    // Input driver. Valid stays high from one transfer into the next when
    // there is no gap, so it is never lowered and raised in one time step.
    // ---------------------------------------------------------------------
    task automatic send_item(t_slew_item it);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < snd_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= it.kind;
        i_goal_axis  <= it.axis;
        i_goal_angle <= it.angle;
        i_new_mode   <= it.mode;
        i_tick_time  <= it.dt;
        do
            @(posedge i_clk);
        while (o_in_stall);
        advance_slewer(it);
        n_items++;
    endtask

    // Wait until every queued command has come out, then let the block settle.
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Write all five registers, one per cycle, while the block is idle.
    task automatic load_regs(int lo, int hi, int vel, int tol, logic [31:0] ids);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_LIM_LO;
        i_cfg_wdata <= CFG_DATA_W'(lo);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_LIM_HI;
        i_cfg_wdata <= CFG_DATA_W'(hi);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_VELOCITY;
        i_cfg_wdata <= CFG_DATA_W'(vel);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_TOLERANCE;
        i_cfg_wdata <= CFG_DATA_W'(tol);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_DRIVE_IDS;
        i_cfg_wdata <= ids;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        lim_a      = lo;
        lim_b      = hi;
        slew_vel   = vel;
        arrive_tol = tol;
        drive_ids  = ids;
    endtask

    // ---------------------------------------------------------------------
    // Directed tests (reset register values: +/-90 deg, 30 deg/s, 0.5 deg tol)
    // ---------------------------------------------------------------------

    // Idle hold, invalid tick times, unused kind/mode codes, bad goal axes,
    // goals clamped at both extremes of the field.
    task automatic test_idle_and_odd_codes();
        t_slew_item odd;
        odd      = tick_item(65536);
        odd.kind = KIND_UNUSED;
        send_item(tick_item(0));
        send_item(odd);
        send_item(noise_item());
        send_item(goal_item(2, 1000));
        send_item(goal_item(3, -1000));
        send_item(goal_item(0, 46080));
        send_item(goal_item(1, -46080));
        send_item(mode_item(MODE_UNUSED));
        send_item(tick_item(131071));
        send_item(mode_item(MODE_IDLE));
        send_item(tick_item(65536));
    endtask

    // Full-size, invalid and zero-length steps, then a reversal at the top stop.
    task automatic test_sweep_reversal();
        send_item(mode_item(MODE_SWEEP));
        send_item(tick_item(65536));
        send_item(tick_item(131071));
        send_item(tick_item(65537));
        send_item(tick_item(1));
        send_item(tick_item(65536));
        send_item(tick_item(65536));
    endtask

    // Axis 1 is already in tolerance; axis 0 lands on the third tick, which
    // ends the move, so axis 1 of that same tick is reported held.
    task automatic test_goto_mid_tick();
        send_item(goal_item(0, 0));
        send_item(goal_item(1, 23000));
        send_item(mode_item(MODE_GOTO));
        repeat (3) send_item(tick_item(65536));
        send_item(tick_item(rand_dt()));
    endtask

    // ---------------------------------------------------------------------
    // Random traffic: mostly well-formed goto and sweep runs, some noise
    // ---------------------------------------------------------------------
    task automatic run_sequences(int budget);
        int sent, pick, k;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                for (int a = 0; a < AXES; a++)
                    send_item(goal_item(a, rand_angle()));
                send_item(mode_item(MODE_GOTO));
                sent += AXES + 1;
                k = 0;
                while (run_mode == MODE_GOTO && k < 12) begin
                    send_item(tick_item(rand_dt()));
                    k++;
                end
                sent += k;
            end else if (pick < 75) begin
                send_item(mode_item(MODE_SWEEP));
                k = $urandom_range(10, 3);
                repeat (k) send_item(tick_item(rand_dt()));
                sent += k + 1;
            end else begin
                k = $urandom_range(4, 1);
                repeat (k) send_item(noise_item());
                sent += k;
            end
        end
    endtask

    task automatic test_random_settings();
        for (int seg = 0; seg < 6; seg++) begin
            wait_for_idle();
            // two settings per idling pattern: sender-light, receiver-light, none
            case (seg / 2)
                0: begin snd_idle_pct = 28; rcv_idle_pct = 59; end
                1: begin snd_idle_pct = 59; rcv_idle_pct = 28; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            case (seg)
                // widest limits, top speed, zero tolerance (goto never ends)
                0: load_regs(-46080, 46080, 65535, 0, 32'hFFFF_FFFF);
                // swapped limits, huge tolerance
                1: load_regs(46080, -46080, 20000, 65535, 32'h0000_0000);
                // swapped narrow limits, standing still
                2: load_regs(5000, -3000, 0, 300, $urandom());
                3: load_regs(rand_angle(), rand_angle(), $urandom_range(65535, 1000),
                             $urandom_range(2000), $urandom());
                // both limits equal
                4: load_regs(100, 100, 40000, 16, 32'hA5C3_5A3C);
                default: load_regs(-23040, 23040, 7680, 128, 32'h0000_0201);
            endcase
            run_sequences(48);
        end
    endtask

    // Receiver holds off while the sender keeps offering ticks, so the block
    // backs up into its input.
    task automatic test_output_backpressure();
        wait_for_idle();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        load_regs(-30000, 30000, 12000, 200, $urandom());
        hold_len = HOLD_CYCLES;
        send_item(mode_item(MODE_SWEEP));
        repeat (12) send_item(tick_item(rand_dt()));
        send_item(mode_item(MODE_GOTO));
        repeat (6) send_item(tick_item(rand_dt()));
    endtask

    // ---------------------------------------------------------------------
    // Receiver stall: a long hold when requested, otherwise random
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            i_out_stall <= 1'b1;
            hold_len--;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Command checker: one expectation per output transfer, oldest first
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_axis_cmd want;
        if (i_rst_n && i_in_valid && o_in_stall)
            n_in_held++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (pending_cmds.size() == 0) begin
                $error("unexpected command transfer: axis %0d angle %0d",
                       o_out_axis, o_command_angle);
                n_fail++;
            end else begin
                want = pending_cmds.pop_front();
                if (o_out_axis !== want.axis) begin
                    $error("out_axis: expected %0d, got %0d", want.axis, o_out_axis);
                    n_fail++;
                end
                if (o_drive_id !== want.motor) begin
                    $error("drive_id: expected %0d, got %0d", want.motor, o_drive_id);
                    n_fail++;
                end
                if (o_command_angle !== want.angle) begin
                    $error("command_angle: expected %0d, got %0d",
                           want.angle, o_command_angle);
                    n_fail++;
                end
                if (o_command_velocity !== want.vel) begin
                    $error("command_velocity: expected %0d, got %0d",
                           want.vel, o_command_velocity);
                    n_fail++;
                end
                if (o_last_axis !== want.last) begin
                    $error("last_axis: expected %0d, got %0d", want.last, o_last_axis);
                    n_fail++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog: too long without any transfer on either channel
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer, %0d commands outstanding",
                     quiet_cycles, pending_cmds.size());
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_LIM_LO;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_kind       = KIND_TICK;
        i_goal_axis  = '0;
        i_goal_angle = '0;
        i_new_mode   = MODE_IDLE;
        i_tick_time  = '0;

        // mirror of the reset state
        lim_a      = -23040;
        lim_b      = 23040;
        slew_vel   = 7680;
        arrive_tol = 128;
        drive_ids  = 32'd513;
        run_mode   = MODE_IDLE;
        for (int a = 0; a < AXES; a++) begin
            goal_pos[a] = 0;
            cmd_pos[a]  = 0;
            sweep_up[a] = 1'b1;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_and_odd_codes();
        test_sweep_reversal();
        test_goto_mid_tick();
        test_random_settings();
        test_output_backpressure();
        wait_for_idle();

        $display("covered %0d input transfers (%0d ticks) at reset values and 7 loaded settings",
                 n_items, n_ticks);
        $display("checked %0d axis commands: %0d goto arrivals, %0d sweep reversals,",
                 n_results, n_goto_done, n_reversals);
        $display("  %0d cycles with the input held off", n_in_held);
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("status: fail");
        end
        $finish;
    end

endmodule
